FILE: rtl/core/rgbpb_pkg.sv
// rgbpb_pkg: shared constants and types of the rgb16 pixel blend unit
`default_nettype none
package rgbpb_pkg;

  localparam int unsigned PIX_W = 16;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 2'd2;

  // blend_mode register codes
  localparam logic [2:0] MODE_ALPHA = 3'd0;
  localparam logic [2:0] MODE_QUARTER = 3'd1;
  localparam logic [2:0] MODE_EIGHTH = 3'd2;
  localparam logic [2:0] MODE_HALF = 3'd3;
  localparam logic [2:0] MODE_COND = 3'd4;
  localparam logic [2:0] MODE_THREEQ = 3'd5;
  localparam logic [2:0] MODE_OPAQUE = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // channel masks, 5:5:5 and 5:6:5
  localparam logic [PIX_W-1:0] M1_555 = 16'h7BDE;
  localparam logic [PIX_W-1:0] M2_555 = 16'h739C;
  localparam logic [PIX_W-1:0] M3_555 = 16'h6318;
  localparam logic [PIX_W-1:0] MRB_555 = 16'h7C1F;
  localparam logic [PIX_W-1:0] MG_555 = 16'h03E0;
  localparam logic [PIX_W-1:0] M1_565 = 16'hF7DE;
  localparam logic [PIX_W-1:0] M2_565 = 16'hE79C;
  localparam logic [PIX_W-1:0] M3_565 = 16'hC718;
  localparam logic [PIX_W-1:0] MRB_565 = 16'hF81F;
  localparam logic [PIX_W-1:0] MG_565 = 16'h07E0;

  localparam int unsigned WGT_W = 5;
  localparam logic [WGT_W-1:0] WGT_MAX = 5'd31;
  localparam int unsigned RB_ACC_W = 21;
  localparam int unsigned G_ACC_W = 17;

  // largest index distance that still counts as opaque in conditional mode
  localparam logic signed [IDX_W:0] COND_DIST = 9'sd2;

  typedef struct packed {
    logic [PIX_W-1:0] new_color;
    logic [PIX_W-1:0] old_color;
    logic             f565;
    logic [2:0]       mode;      // conditional and unused codes already resolved
    logic [WGT_W-1:0] alpha;
  } s1_t;

  typedef struct packed {
    logic [RB_ACC_W-1:0] rb_acc;
    logic [G_ACC_W-1:0]  g_acc;
    logic [PIX_W-1:0]    plain;  // result of every mode but alpha
    logic                f565;
    logic                use_alpha;
  } s2_t;

endpackage
`default_nettype wire

FILE: rtl/core/rgbpb_in_if.sv
// rgbpb_in_if: input item channel of the pixel blend unit
`default_nettype none
interface rgbpb_in_if;
  logic                           valid;
  logic                           ready;
  logic [rgbpb_pkg::PIX_W-1:0]    new_color;
  logic [rgbpb_pkg::PIX_W-1:0]    old_color;
  logic [rgbpb_pkg::IDX_W-1:0]    source_index;
  logic [rgbpb_pkg::IDX_W-1:0]    white_map_index;

  modport source (output valid, output new_color, output old_color,
                  output source_index, output white_map_index, input ready);
  modport sink (input valid, input new_color, input old_color,
                input source_index, input white_map_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rgbpb_out_if.sv
// rgbpb_out_if: result item channel of the pixel blend unit
`default_nettype none
interface rgbpb_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgbpb_pkg::PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rgb16_pixel_blend_unit.sv
// rgb16_pixel_blend_unit: three-stage 16-bit pixel blender with stall handling
// decode, weight and select stages lie between input accept and pixel_out valid
// one item per cycle while not stalled; each stage holds when the next is full
// the alpha products (four 16x5 multiplies) all sit in the second stage
// reset: all stage valid bits clear; pixel_format 1, blend_mode 3, alpha_level 255
`default_nettype none
module rgb16_pixel_blend_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [rgbpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rgbpb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  rgbpb_in_if.sink                                   in_pix,
  rgbpb_out_if.source                                out_pix
);

  // configuration registers
  logic       pixel_format_r;
  logic [2:0] blend_mode_r;
  logic [7:0] alpha_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= 1'b1;
      blend_mode_r <= rgbpb_pkg::MODE_HALF;
      alpha_level_r <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbpb_pkg::CFG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[0];
        rgbpb_pkg::CFG_BLEND_MODE:   blend_mode_r <= cfg_wdata[2:0];
        rgbpb_pkg::CFG_ALPHA_LEVEL:  alpha_level_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic load1, load2, load3;

  assign load3 = !v3_r || out_pix.ready;
  assign load2 = !v2_r || load3;
  assign load1 = !v1_r || load2;
  assign in_pix.ready = load1;

  always_comb begin
    v1_nxt = load1 ? in_pix.valid : v1_r;
    v2_nxt = load2 ? v1_r : v2_r;
    v3_nxt = load3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: mode decode and conditional test
  rgbpb_pkg::s1_t s1_nxt, s1_r;
  logic signed [rgbpb_pkg::IDX_W:0] idx_diff;
  logic near_idx;

  always_comb begin
    idx_diff = $signed({1'b0, in_pix.source_index}) - $signed({1'b0, in_pix.white_map_index});
    near_idx = (idx_diff <= rgbpb_pkg::COND_DIST) && (idx_diff >= -rgbpb_pkg::COND_DIST);
    s1_nxt.new_color = in_pix.new_color;
    s1_nxt.old_color = in_pix.old_color;
    s1_nxt.f565 = pixel_format_r;
    s1_nxt.alpha = alpha_level_r[7:3];
    unique case (blend_mode_r)
      rgbpb_pkg::MODE_COND:
        s1_nxt.mode = near_idx ? rgbpb_pkg::MODE_OPAQUE : rgbpb_pkg::MODE_HALF;
      rgbpb_pkg::MODE_UNUSED: s1_nxt.mode = rgbpb_pkg::MODE_HALF;
      default: s1_nxt.mode = blend_mode_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load1 && in_pix.valid) begin
      s1_r <= s1_nxt;
    end
  end

  // stage 2: weighted sums and the shift-and-mask blends
  rgbpb_pkg::s2_t s2_nxt, s2_r;
  logic [rgbpb_pkg::PIX_W-1:0] m1, m2, m3, mrb, mg;
  logic [rgbpb_pkg::PIX_W-1:0] n_v, o_v, qd, th, half_v;
  logic [rgbpb_pkg::WGT_W-1:0] a_rem;

  always_comb begin
    n_v = s1_r.new_color;
    o_v = s1_r.old_color;
    m1 = s1_r.f565 ? rgbpb_pkg::M1_565 : rgbpb_pkg::M1_555;
    m2 = s1_r.f565 ? rgbpb_pkg::M2_565 : rgbpb_pkg::M2_555;
    m3 = s1_r.f565 ? rgbpb_pkg::M3_565 : rgbpb_pkg::M3_555;
    mrb = s1_r.f565 ? rgbpb_pkg::MRB_565 : rgbpb_pkg::MRB_555;
    mg = s1_r.f565 ? rgbpb_pkg::MG_565 : rgbpb_pkg::MG_555;
    a_rem = rgbpb_pkg::WGT_MAX - s1_r.alpha;

    s2_nxt.rb_acc = rgbpb_pkg::RB_ACC_W'((o_v & mrb) * a_rem)
                  + rgbpb_pkg::RB_ACC_W'((n_v & mrb) * s1_r.alpha);
    s2_nxt.g_acc = rgbpb_pkg::G_ACC_W'((o_v & mg) * a_rem)
                 + rgbpb_pkg::G_ACC_W'((n_v & mg) * s1_r.alpha);

    qd = (o_v & m1) >> 1;
    th = (n_v & m1) >> 1;
    half_v = ((n_v & m1) >> 1) + ((o_v & m1) >> 1);
    unique case (s1_r.mode)
      rgbpb_pkg::MODE_QUARTER: s2_nxt.plain = ((n_v & m2) >> 2) + qd + ((qd & m1) >> 1);
      rgbpb_pkg::MODE_EIGHTH:  s2_nxt.plain = o_v - ((o_v & m3) >> 3) + ((n_v & m3) >> 3);
      rgbpb_pkg::MODE_THREEQ:  s2_nxt.plain = th + ((th & m1) >> 1) + ((o_v & m2) >> 2);
      rgbpb_pkg::MODE_OPAQUE:  s2_nxt.plain = n_v;
      default:                 s2_nxt.plain = half_v;
    endcase
    s2_nxt.f565 = s1_r.f565;
    s2_nxt.use_alpha = (s1_r.mode == rgbpb_pkg::MODE_ALPHA);
  end

  always_ff @(posedge clk) begin
    if (load2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  // stage 3: scale the alpha sums and pick the result
  logic [rgbpb_pkg::PIX_W-1:0] alpha_pix, pix_nxt, pix_r;
  logic [rgbpb_pkg::PIX_W-1:0] mrb3, mg3;
  logic [rgbpb_pkg::RB_ACC_W-1:0] rb_sh;
  logic [rgbpb_pkg::G_ACC_W-1:0] g_sh;

  always_comb begin
    mrb3 = s2_r.f565 ? rgbpb_pkg::MRB_565 : rgbpb_pkg::MRB_555;
    mg3 = s2_r.f565 ? rgbpb_pkg::MG_565 : rgbpb_pkg::MG_555;
    rb_sh = s2_r.rb_acc >> rgbpb_pkg::WGT_W;
    g_sh = s2_r.g_acc >> rgbpb_pkg::WGT_W;
    alpha_pix = (rb_sh[rgbpb_pkg::PIX_W-1:0] & mrb3) | (g_sh[rgbpb_pkg::PIX_W-1:0] & mg3);
    pix_nxt = s2_r.use_alpha ? alpha_pix : s2_r.plain;
  end

  always_ff @(posedge clk) begin
    if (load3 && v2_r) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_pix.valid = v3_r;
  assign out_pix.pixel_out = pix_r;

  // a full, stalled pipeline must refuse new items
  assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_pix.ready) |-> !in_pix.ready)
    else $error("input accepted while pipeline full and stalled");

  // a result only appears when the middle stage held an item
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result valid without an item in stage 2");

  // no result in the cycle after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_pix.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

FILE: tb/rgb16_pixel_blend_unit_tb.sv
// testbench for the rgb16 pixel blend unit: random and directed pixels checked against a predictor
`default_nettype none
module rgb16_pixel_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_PHASES = 40;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned HOLD_MIN_PENDING = 6;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned WEIGHT_FULL = 31;
  localparam int OPAQUE_DIST = 2;

  typedef struct packed {
    logic [rgbpb_pkg::PIX_W-1:0] new_color;
    logic [rgbpb_pkg::PIX_W-1:0] old_color;
    logic [rgbpb_pkg::IDX_W-1:0] source_index;
    logic [rgbpb_pkg::IDX_W-1:0] white_map_index;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [rgbpb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rgbpb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rgbpb_in_if in_pix_if ();
  rgbpb_out_if out_pix_if ();

  rgb16_pixel_blend_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix_if),
    .out_pix   (out_pix_if)
  );

  // shadow of the blend registers, written only while the pipe is empty
  logic fmt_565 = 1'b1;
  logic [2:0] mode_sel = rgbpb_pkg::MODE_HALF;
  logic [7:0] alpha_lvl = 8'd255;

  pixel_req_t pending_px[$];
  logic [rgbpb_pkg::PIX_W-1:0] blended_px[$];
  pixel_req_t bus_px;
  logic [rgbpb_pkg::PIX_W-1:0] want_px;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned accepted_px = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  logic src_steady = 1'b0;
  logic snk_steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [rgbpb_pkg::PIX_W-1:0] blend_pixel(input pixel_req_t rq);
    logic [31:0] n, o, m1, m2, m3, mrb, mg, d, h, half_px, wa, wb, rb, g, r;
    int idx_gap;
    n = 32'(rq.new_color);
    o = 32'(rq.old_color);
    m1 = fmt_565 ? 32'hF7DE : 32'h7BDE;
    m2 = fmt_565 ? 32'hE79C : 32'h739C;
    m3 = fmt_565 ? 32'hC718 : 32'h6318;
    mrb = fmt_565 ? 32'hF81F : 32'h7C1F;
    mg = fmt_565 ? 32'h07E0 : 32'h03E0;
    half_px = ((n & m1) >> 1) + ((o & m1) >> 1);
    case (mode_sel)
      rgbpb_pkg::MODE_ALPHA: begin
        wa = 32'(alpha_lvl[7:3]);
        wb = WEIGHT_FULL - wa;
        rb = (((o & mrb) * wb + (n & mrb) * wa) >> 5) & mrb;
        g = (((o & mg) * wb + (n & mg) * wa) >> 5) & mg;
        r = rb | g;
      end
      rgbpb_pkg::MODE_QUARTER: begin
        d = (o & m1) >> 1;
        r = ((n & m2) >> 2) + d + ((d & m1) >> 1);
      end
      rgbpb_pkg::MODE_EIGHTH: r = (o - ((o & m3) >> 3)) + ((n & m3) >> 3);
      rgbpb_pkg::MODE_COND: begin
        idx_gap = int'(rq.source_index) - int'(rq.white_map_index);
        r = (idx_gap > OPAQUE_DIST || idx_gap < -OPAQUE_DIST) ? half_px : n;
      end
      rgbpb_pkg::MODE_THREEQ: begin
        h = (n & m1) >> 1;
        r = h + ((h & m1) >> 1) + ((o & m2) >> 2);
      end
      rgbpb_pkg::MODE_OPAQUE: r = n;
      default: r = half_px;
    endcase
    return r[rgbpb_pkg::PIX_W-1:0];
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [rgbpb_pkg::PIX_W-1:0] random_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rgbpb_pkg::PIX_W'($urandom());
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t rq;
    rq.new_color = random_color();
    rq.old_color = random_color();
    rq.source_index = rgbpb_pkg::IDX_W'($urandom_range(0, 255));
    // keep the two indexes near each other half the time for conditional mode
    if ($urandom_range(0, 1))
      rq.white_map_index = rgbpb_pkg::IDX_W'(int'(rq.source_index) + $urandom_range(0, 6) - 3);
    else
      rq.white_map_index = rgbpb_pkg::IDX_W'($urandom_range(0, 255));
    return rq;
  endfunction

  // source side
  always @(posedge clk) begin
    logic present;
    if (!rst_n) begin
      in_pix_if.valid <= 1'b0;
    end else begin
      present = in_pix_if.valid;
      if (in_pix_if.valid && in_pix_if.ready) begin
        blended_px.push_back(blend_pixel(bus_px));
        accepted_px <= accepted_px + 1;
        present = 1'b0;
      end
      if (!present) begin
        if (src_gap != 0) begin
          src_gap = src_gap - 1;
        end else if (pending_px.size() != 0) begin
          bus_px = pending_px.pop_front();
          present = 1'b1;
          src_gap = src_steady ? 0 : idle_cycles();
          in_pix_if.new_color <= bus_px.new_color;
          in_pix_if.old_color <= bus_px.old_color;
          in_pix_if.source_index <= bus_px.source_index;
          in_pix_if.white_map_index <= bus_px.white_map_index;
        end
      end
      in_pix_if.valid <= present;
    end
  end

  // long sink hold-off once the run is under way, so the pipe backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_px >= HOLD_AT
                 && pending_px.size() >= HOLD_MIN_PENDING) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sink side and result check
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_pix_if.ready <= 1'b0;
    end else begin
      if (out_pix_if.valid && out_pix_if.ready) begin
        if (blended_px.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel_out expected none actual %h", $time, out_pix_if.pixel_out);
        end else begin
          want_px = blended_px.pop_front();
          if (out_pix_if.pixel_out !== want_px) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: pixel_out expected %h actual %h", $time, want_px,
                       out_pix_if.pixel_out);
          end
        end
      end
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap = snk_gap - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        snk_gap = snk_steady ? 0 : idle_cycles();
      end
      out_pix_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [rgbpb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rgbpb_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_blend(input logic fmt, input logic [2:0] md, input logic [7:0] alpha);
    write_reg(rgbpb_pkg::CFG_PIXEL_FORMAT, rgbpb_pkg::CFG_DATA_W'(fmt));
    write_reg(rgbpb_pkg::CFG_BLEND_MODE, rgbpb_pkg::CFG_DATA_W'(md));
    write_reg(rgbpb_pkg::CFG_ALPHA_LEVEL, alpha);
    cfg_we <= 1'b0;
    fmt_565 = fmt;
    mode_sel = md;
    alpha_lvl = alpha;
  endtask

  task automatic add_px(input logic [rgbpb_pkg::PIX_W-1:0] n,
                        input logic [rgbpb_pkg::PIX_W-1:0] o,
                        input logic [rgbpb_pkg::IDX_W-1:0] si,
                        input logic [rgbpb_pkg::IDX_W-1:0] wi);
    pixel_req_t rq;
    rq.new_color = n;
    rq.old_color = o;
    rq.source_index = si;
    rq.white_map_index = wi;
    pending_px.push_back(rq);
  endtask

  // look at the queues between edges so every update of the edge has landed
  task automatic drain_pixels();
    do @(negedge clk);
    while (pending_px.size() != 0 || in_pix_if.valid || blended_px.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    logic fmt;
    logic [2:0] md;
    logic [7:0] alpha;
    int unsigned count;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_pix_if.valid = 1'b0;
    in_pix_if.new_color = '0;
    in_pix_if.old_color = '0;
    in_pix_if.source_index = '0;
    in_pix_if.white_map_index = '0;
    out_pix_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 5:6:5, half blend, full alpha
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    add_px(16'h0000, 16'hFFFF, 8'd255, 8'd255);
    drain_pixels();
    // alpha at full level leaves 1/32 short of the new pixel; bit 15 dropped in 5:5:5
    set_blend(1'b0, rgbpb_pkg::MODE_ALPHA, 8'd255);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    add_px(16'h8000, 16'hFFFF, 8'd0, 8'd0);
    drain_pixels();
    set_blend(1'b1, rgbpb_pkg::MODE_ALPHA, 8'd0);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    drain_pixels();
    set_blend(1'b1, rgbpb_pkg::MODE_QUARTER, 8'd0);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    add_px(16'h0000, 16'hFFFF, 8'd0, 8'd0);
    drain_pixels();
    // eighth blend keeps bit 15 of the old pixel in 5:5:5
    set_blend(1'b0, rgbpb_pkg::MODE_EIGHTH, 8'd128);
    add_px(16'h0000, 16'hFFFF, 8'd0, 8'd0);
    add_px(16'hFFFF, 16'h8000, 8'd0, 8'd0);
    drain_pixels();
    set_blend(1'b1, rgbpb_pkg::MODE_EIGHTH, 8'd128);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    drain_pixels();
    set_blend(1'b0, rgbpb_pkg::MODE_HALF, 8'd128);
    add_px(16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
    drain_pixels();
    // conditional: distance two stays opaque, three falls back to half
    set_blend(1'b1, rgbpb_pkg::MODE_COND, 8'd128);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd2);
    add_px(16'hFFFF, 16'h0000, 8'd2, 8'd0);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd3);
    add_px(16'hFFFF, 16'h0000, 8'd3, 8'd0);
    add_px(16'h1234, 16'hFEDC, 8'd255, 8'd0);
    add_px(16'h1234, 16'hFEDC, 8'd0, 8'd255);
    add_px(16'h1234, 16'hFEDC, 8'd255, 8'd253);
    drain_pixels();
    set_blend(1'b0, rgbpb_pkg::MODE_THREEQ, 8'd128);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    add_px(16'h0000, 16'hFFFF, 8'd0, 8'd0);
    drain_pixels();
    // opaque keeps bit 15 of the new pixel even in 5:5:5
    set_blend(1'b0, rgbpb_pkg::MODE_OPAQUE, 8'd128);
    add_px(16'hFFFF, 16'h0000, 8'd0, 8'd0);
    drain_pixels();
    set_blend(1'b1, rgbpb_pkg::MODE_UNUSED, 8'd128);
    add_px(16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
    drain_pixels();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      md = 3'(ph % 8);
      if (ph < 16)
        fmt = 1'((ph / 8) % 2);
      else
        fmt = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: alpha = 8'd0;
        1: alpha = 8'd255;
        default: alpha = 8'($urandom_range(0, 255));
      endcase
      set_blend(fmt, md, alpha);
      src_steady <= (ph % 5 == 0);
      snk_steady <= (ph % 7 == 3);
      count = $urandom_range(18, 24);
      repeat (count) pending_px.push_back(random_pixel());
      drain_pixels();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
